/* sv/lfpg_pkg.sv */
// Package for the LED flash pattern generator: op codes, sequencer phase codes,
// register indexes and duty scaling constants. No dependencies.
`default_nettype none

package lfpg_pkg;

    // Full-scale PWM duty; the computed duty is kept to its low 8 bits.
    localparam int unsigned MAX_DUTY = 255;
    // MAX_DUTY = 255 * DUTY_HI + DUTY_LO, so level*MAX_DUTY/255 splits into
    // level*DUTY_HI plus a small quotient level*DUTY_LO/255.
    localparam int unsigned DUTY_HI  = MAX_DUTY / 255;
    localparam int unsigned DUTY_LO  = MAX_DUTY % 255;
    localparam logic [15:0] MAX_DUTY_W = 16'(MAX_DUTY);
    localparam logic [8:0]  DUTY_HI_W  = 9'(DUTY_HI);
    localparam logic [7:0]  DUTY_LO_W  = 8'(DUTY_LO);

    // Operation codes carried in s_tuser.
    localparam logic [1:0] OP_FLASH = 2'd0;
    localparam logic [1:0] OP_ON    = 2'd1;
    localparam logic [1:0] OP_OFF   = 2'd2;
    localparam logic [1:0] OP_PWM   = 2'd3;

    // Flash sequencer phases.
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_DELAY     = 3'd1;
    localparam logic [2:0] PH_PULSE_ON  = 3'd2;
    localparam logic [2:0] PH_ON_WAIT   = 3'd3;
    localparam logic [2:0] PH_PULSE_OFF = 3'd4;
    localparam logic [2:0] PH_OFF_WAIT  = 3'd5;
    localparam logic [2:0] PH_BURST_CHK = 3'd6;
    localparam logic [2:0] PH_PAUSE     = 3'd7;

    // Configuration register indexes (byte address = 4 * index).
    localparam logic [2:0] REG_ON_TIME     = 3'd0;
    localparam logic [2:0] REG_OFF_TIME    = 3'd1;
    localparam logic [2:0] REG_PAUSE_TIME  = 3'd2;
    localparam logic [2:0] REG_PULSES      = 3'd3;
    localparam logic [2:0] REG_START_DELAY = 3'd4;
    localparam logic [2:0] REG_FLASH_RAMP  = 3'd5;
    localparam logic [2:0] REG_FLASH_FLOOR = 3'd6;
    localparam logic [2:0] REG_INVERT      = 3'd7;

endpackage

`default_nettype wire

/* sv/led_flash_pattern_generator_top.sv */
// Top level of the LED flash pattern generator: APB register file, flash
// sequencer, brightness ramps, duty scaling and output register. Uses lfpg_pkg.
//
// Usage:
//   Each transfer on the s_ channel is one service call. s_tuser holds the op
//   (flash step, full on, off step, set pwm level) and s_tdata holds the
//   millisecond and microsecond times, the pwm level and the off-ramp settings.
//   Every call yields exactly one result transfer on the m_ channel: the scaled,
//   optionally inverted duty in m_tdata and the pulse-on flag in m_tuser.
//   The whole update is done in the cycle the call is accepted, so the result
//   appears in the cycle after. One call is taken every cycle; the rate is set by
//   the single output register, which accepts a new call whenever it is empty
//   or its result is taken in the same cycle.
//   When the receiver stalls, the result holds in m_tdata/m_tuser and s_tready
//   drops until the result is taken, so nothing is lost or repeated.
//   Synchronous active-low reset clears the sequencer and ramp state, empties
//   the output register and loads the register defaults (one pulse per burst,
//   all other registers zero).
//   Registers must be written through the APB port while no call is in flight,
//   which the block itself does not check; pready is always high and a read returns the register value.
`default_nettype none

module led_flash_pattern_generator_top
    import lfpg_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // APB configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Service call input.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata, low bit up: now_ms[31:0], now_us[63:32], pwm_level[71:64],
    // off_ramp_us[87:72], off_floor[95:88].
    input  wire logic [95:0] s_tdata,
    // s_tuser: op[1:0].
    input  wire logic [1:0]  s_tuser,
    // Result output.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: duty[7:0].
    output logic      [7:0]  m_tdata,
    // m_tuser: pulse_start[0].
    output logic      [0:0]  m_tuser
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [31:0] on_time_reg;
    logic [31:0] off_time_reg;
    logic [31:0] pause_time_reg;
    logic [7:0]  pulses_reg;
    logic [15:0] start_delay_reg;
    logic [15:0] flash_ramp_reg;
    logic [7:0]  flash_floor_reg;
    logic        invert_reg;

    logic        cfg_write;
    logic [2:0]  cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_time_reg     <= '0;
            off_time_reg    <= '0;
            pause_time_reg  <= '0;
            pulses_reg      <= 8'd1;
            start_delay_reg <= '0;
            flash_ramp_reg  <= '0;
            flash_floor_reg <= '0;
            invert_reg      <= 1'b0;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_ON_TIME:     on_time_reg     <= pwdata;
                REG_OFF_TIME:    off_time_reg    <= pwdata;
                REG_PAUSE_TIME:  pause_time_reg  <= pwdata;
                REG_PULSES:      pulses_reg      <= pwdata[7:0];
                REG_START_DELAY: start_delay_reg <= pwdata[15:0];
                REG_FLASH_RAMP:  flash_ramp_reg  <= pwdata[15:0];
                REG_FLASH_FLOOR: flash_floor_reg <= pwdata[7:0];
                REG_INVERT:      invert_reg      <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_ON_TIME:     prdata = on_time_reg;
            REG_OFF_TIME:    prdata = off_time_reg;
            REG_PAUSE_TIME:  prdata = pause_time_reg;
            REG_PULSES:      prdata = {24'd0, pulses_reg};
            REG_START_DELAY: prdata = {16'd0, start_delay_reg};
            REG_FLASH_RAMP:  prdata = {16'd0, flash_ramp_reg};
            REG_FLASH_FLOOR: prdata = {24'd0, flash_floor_reg};
            REG_INVERT:      prdata = {31'd0, invert_reg};
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input fields.
    // ------------------------------------------------------------------
    logic [1:0]  in_op;
    logic [31:0] in_now_ms;
    logic [31:0] in_now_us;
    logic [7:0]  in_pwm_level;
    logic [15:0] in_off_ramp_us;
    logic [7:0]  in_off_floor;

    assign in_op          = s_tuser;
    assign in_now_ms      = s_tdata[31:0];
    assign in_now_us      = s_tdata[63:32];
    assign in_pwm_level   = s_tdata[71:64];
    assign in_off_ramp_us = s_tdata[87:72];
    assign in_off_floor   = s_tdata[95:88];

    // ------------------------------------------------------------------
    // Handshake and output register.
    // ------------------------------------------------------------------
    logic       m_tvalid_reg;
    logic [7:0] duty_reg;
    logic       pulse_reg;
    logic       s_accept;

    assign s_tready = aresetn && (!m_tvalid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = duty_reg;
    assign m_tuser  = pulse_reg;

    // ------------------------------------------------------------------
    // Sequencer and ramp state.
    // ------------------------------------------------------------------
    logic [2:0]  phase_reg,        phase_next;
    logic [31:0] phase_mark_reg,   phase_mark_next;
    logic [7:0]  pulse_count_reg,  pulse_count_next;
    logic        ramping_up_reg,   ramping_up_next;
    logic        ramping_down_reg, ramping_down_next;
    logic        start_flag_reg,   start_flag_next;
    logic [7:0]  flash_level_reg,  flash_level_next;
    logic [31:0] flash_mark_reg,   flash_mark_next;
    logic [7:0]  off_level_reg,    off_level_next;
    logic [31:0] off_mark_reg,     off_mark_next;
    logic [7:0]  level;
    logic        pulse_out;

    always_comb begin
        logic [31:0] dt_ms;
        logic [31:0] dt_flash_us;
        logic [31:0] dt_off_us;

        dt_ms       = in_now_ms - phase_mark_reg;
        dt_flash_us = in_now_us - flash_mark_reg;
        dt_off_us   = in_now_us - off_mark_reg;

        phase_next        = phase_reg;
        phase_mark_next   = phase_mark_reg;
        pulse_count_next  = pulse_count_reg;
        ramping_up_next   = ramping_up_reg;
        ramping_down_next = ramping_down_reg;
        start_flag_next   = start_flag_reg;
        flash_level_next  = flash_level_reg;
        flash_mark_next   = flash_mark_reg;
        off_level_next    = off_level_reg;
        off_mark_next     = off_mark_reg;
        level             = '0;
        pulse_out         = 1'b0;

        if (in_op == OP_FLASH) begin
            // One sequencer step, then the flash ramp sees the updated flags.
            case (phase_reg)
                PH_IDLE: begin
                    phase_mark_next = in_now_ms;
                    phase_next      = PH_DELAY;
                end
                PH_DELAY: begin
                    if (dt_ms >= {16'd0, start_delay_reg}) phase_next = PH_PULSE_ON;
                end
                PH_PULSE_ON: begin
                    ramping_up_next   = 1'b1;
                    ramping_down_next = 1'b0;
                    pulse_count_next  = pulse_count_reg + 8'd1;
                    phase_mark_next   = in_now_ms;
                    phase_next        = PH_ON_WAIT;
                    start_flag_next   = 1'b1;
                end
                PH_ON_WAIT: begin
                    if (dt_ms >= on_time_reg) begin
                        phase_next      = PH_PULSE_OFF;
                        start_flag_next = 1'b0;
                    end
                end
                PH_PULSE_OFF: begin
                    ramping_down_next = 1'b1;
                    ramping_up_next   = 1'b0;
                    phase_mark_next   = in_now_ms;
                    phase_next        = PH_OFF_WAIT;
                end
                PH_OFF_WAIT: begin
                    if (dt_ms >= off_time_reg) phase_next = PH_BURST_CHK;
                end
                PH_BURST_CHK: begin
                    // A burst length of zero behaves like a single pulse.
                    if (pulse_count_reg >= pulses_reg) begin
                        pulse_count_next = '0;
                        phase_mark_next  = in_now_ms;
                        phase_next       = PH_PAUSE;
                    end else begin
                        phase_next = PH_PULSE_ON;
                    end
                end
                default: begin
                    if (dt_ms >= pause_time_reg) phase_next = PH_PULSE_ON;
                end
            endcase

            if (flash_ramp_reg != 16'd0) begin
                if (dt_flash_us >= {16'd0, flash_ramp_reg}) begin
                    flash_mark_next = in_now_us;
                    if (ramping_up_next && flash_level_next != 8'hFF) begin
                        flash_level_next = flash_level_next + 8'd1;
                    end
                    if (flash_level_next == 8'hFF || ramping_down_next) begin
                        ramping_up_next = 1'b0;
                    end
                    // Below the floor the level stays put while ramping down.
                    if (ramping_down_next && flash_level_next > flash_floor_reg) begin
                        flash_level_next = flash_level_next - 8'd1;
                    end
                    if (flash_level_next == flash_floor_reg) begin
                        ramping_down_next = 1'b0;
                    end
                end
            end else begin
                if (ramping_up_next) begin
                    flash_level_next = 8'hFF;
                    ramping_up_next  = 1'b0;
                end
                if (ramping_down_next) begin
                    flash_level_next  = flash_floor_reg;
                    ramping_down_next = 1'b0;
                end
            end

            level     = flash_level_next;
            pulse_out = start_flag_next;
        end else begin
            // Any other op restarts the sequencer; start_flag is left alone.
            phase_next       = PH_IDLE;
            pulse_count_next = '0;
            case (in_op)
                OP_ON: level = 8'hFF;
                OP_OFF: begin
                    if (in_off_ramp_us != 16'd0) begin
                        if (dt_off_us >= {16'd0, in_off_ramp_us}) begin
                            off_mark_next = in_now_us;
                            if (off_level_reg > in_off_floor) begin
                                off_level_next = off_level_reg - 8'd1;
                            end
                        end
                    end else begin
                        off_level_next = in_off_floor;
                    end
                    level = off_level_next;
                end
                default: level = in_pwm_level;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Duty scaling: level*MAX_DUTY/255, split as level*DUTY_HI plus
    // (level*DUTY_LO)/255; the small quotient uses the exact 16-bit form
    // y/255 = (y + (y >> 8) + 1) >> 8.
    // ------------------------------------------------------------------
    logic [15:0] lo_prod;
    logic [16:0] lo_sum;
    logic [7:0]  lo_quot;
    logic [16:0] hi_prod;
    logic [15:0] duty_raw;
    logic [15:0] duty_sel;

    assign lo_prod  = level * DUTY_LO_W;
    assign lo_sum   = {1'b0, lo_prod} + {9'd0, lo_prod[15:8]} + 17'd1;
    assign lo_quot  = lo_sum[15:8];
    assign hi_prod  = level * DUTY_HI_W;
    assign duty_raw = hi_prod[15:0] + {8'd0, lo_quot};
    assign duty_sel = invert_reg ? (MAX_DUTY_W - duty_raw) : duty_raw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg     <= 1'b0;
            phase_reg        <= PH_IDLE;
            phase_mark_reg   <= '0;
            pulse_count_reg  <= '0;
            ramping_up_reg   <= 1'b0;
            ramping_down_reg <= 1'b0;
            start_flag_reg   <= 1'b0;
            flash_level_reg  <= '0;
            flash_mark_reg   <= '0;
            off_level_reg    <= '0;
            off_mark_reg     <= '0;
        end else begin
            if (s_accept) begin
                m_tvalid_reg     <= 1'b1;
                phase_reg        <= phase_next;
                phase_mark_reg   <= phase_mark_next;
                pulse_count_reg  <= pulse_count_next;
                ramping_up_reg   <= ramping_up_next;
                ramping_down_reg <= ramping_down_next;
                start_flag_reg   <= start_flag_next;
                flash_level_reg  <= flash_level_next;
                flash_mark_reg   <= flash_mark_next;
                off_level_reg    <= off_level_next;
                off_mark_reg     <= off_mark_next;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            duty_reg  <= duty_sel[7:0];
            pulse_reg <= pulse_out;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // Any op other than a flash step sends the sequencer back to idle.
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (s_tuser != OP_FLASH) |=> (phase_reg == PH_IDLE) && (pulse_count_reg == 8'd0))
        else $error("sequencer not restarted by a non-flash op");

    // Only a flash step can report a pulse-on result.
    a_pulse_flash_only: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (s_tuser != OP_FLASH) |=> m_tvalid && !m_tuser[0])
        else $error("pulse flag set on a non-flash result");

    // With instant switching, a flash step never leaves a ramp pending.
    a_instant_ramp: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (s_tuser == OP_FLASH) && (flash_ramp_reg == 16'd0) && !cfg_write
        |=> !ramping_up_reg && !ramping_down_reg)
        else $error("ramp flags left set with zero ramp period");

    // A result is never dropped: a new call is only taken if the old result leaves.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tready |-> !s_accept)
        else $error("call accepted over a stalled result");

endmodule

`default_nettype wire
